// ----- rtl/core/hfps_pkg.sv -----
// Shared types, constants and helper functions of the Helmholtz five-point stencil.
package hfps_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;

    localparam int SAMPLE_W  = 32;
    localparam int GHOST_W   = SAMPLE_W + 1;
    localparam int CFG_W     = 40;
    localparam int CFG_IDX_W = 3;
    localparam int SIZE_W    = 7;

    localparam int SIDE_WEST  = 0;
    localparam int SIDE_EAST  = 1;
    localparam int SIDE_SOUTH = 2;
    localparam int SIDE_NORTH = 3;

    localparam logic [39:0] INV_DX2_RST = 40'd65536;
    localparam logic [39:0] INV_DY2_RST = 40'd65536;
    localparam logic [6:0]  SIZE_RST    = 7'd64;

    localparam logic [31:0] SAT_POS = 32'h7fff_ffff;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_DX2        = 3'd0,
        REG_INV_DY2        = 3'd1,
        REG_LAMBDA         = 3'd2,
        REG_NEUMANN_SIDES  = 3'd3,
        REG_NEIGHBOR_SIDES = 3'd4,
        REG_INTERNAL_BC    = 3'd5,
        REG_WIDTH          = 3'd6,
        REG_HEIGHT         = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [39:0] inv_dx2;
        logic [39:0] inv_dy2;
        logic [31:0] lambda_coeff;
        logic [3:0]  neumann_sides;
        logic [3:0]  neighbor_sides;
        logic        internal_bc;
        logic [6:0]  width_in_use;
        logic [6:0]  height_in_use;
    } cfg_t;

    // One interior cell with its four neighbors, ghosts already substituted.
    typedef struct packed {
        logic [SAMPLE_W-1:0] u;
        logic [GHOST_W-1:0]  uw;
        logic [GHOST_W-1:0]  ue;
        logic [GHOST_W-1:0]  us;
        logic [GHOST_W-1:0]  un;
        logic                last;
    } cell_t;

    function automatic logic [GHOST_W-1:0] ghost_value(
        input logic               has_neighbor,
        input logic               neumann,
        input logic               internal_bc,
        input logic [GHOST_W-1:0] raw,
        input logic [GHOST_W-1:0] adj
    );
        logic [GHOST_W-1:0] neg;
        neg = -adj;
        if (has_neighbor) begin
            return internal_bc ? neg : raw;
        end
        return neumann ? adj : neg;
    endfunction

endpackage

// ----- rtl/core/hfps_ram.sv -----
// Generic single-write, single-read RAM with registered read data (read-first).
module hfps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 66
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/hfps_cfg.sv -----
// Configuration register file of the stencil.
module hfps_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [hfps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hfps_pkg::CFG_W-1:0]     cfg_data,
    output hfps_pkg::cfg_t                 cfg
);

    hfps_pkg::cfg_t cfg_reg;
    hfps_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (hfps_pkg::cfg_reg_t'(cfg_index))
                hfps_pkg::REG_INV_DX2:        cfg_next.inv_dx2        = cfg_data[39:0];
                hfps_pkg::REG_INV_DY2:        cfg_next.inv_dy2        = cfg_data[39:0];
                hfps_pkg::REG_LAMBDA:         cfg_next.lambda_coeff   = cfg_data[31:0];
                hfps_pkg::REG_NEUMANN_SIDES:  cfg_next.neumann_sides  = cfg_data[3:0];
                hfps_pkg::REG_NEIGHBOR_SIDES: cfg_next.neighbor_sides = cfg_data[3:0];
                hfps_pkg::REG_INTERNAL_BC:    cfg_next.internal_bc    = cfg_data[0];
                hfps_pkg::REG_WIDTH:          cfg_next.width_in_use   = cfg_data[6:0];
                hfps_pkg::REG_HEIGHT:         cfg_next.height_in_use  = cfg_data[6:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_dx2        <= hfps_pkg::INV_DX2_RST;
            cfg_reg.inv_dy2        <= hfps_pkg::INV_DY2_RST;
            cfg_reg.lambda_coeff   <= '0;
            cfg_reg.neumann_sides  <= '0;
            cfg_reg.neighbor_sides <= '0;
            cfg_reg.internal_bc    <= 1'b0;
            cfg_reg.width_in_use   <= hfps_pkg::SIZE_RST;
            cfg_reg.height_in_use  <= hfps_pkg::SIZE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/hfps_window.sv -----
// Raster counters, the two row stores and the stencil window with ghost substitution.
module hfps_window #(
    parameter int MAX_WIDTH  = hfps_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = hfps_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hfps_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [hfps_pkg::SAMPLE_W-1:0] sample_value,
    output hfps_pkg::cell_t               stencil,
    output logic                          cell_valid,
    input  logic                          cell_take
);

    localparam int DEPTH = MAX_WIDTH + 2;
    localparam int COL_W = $clog2(DEPTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             bank_reg, bank_next;
    logic             cell_valid_reg, cell_valid_next;
    hfps_pkg::cell_t  cell_reg, cell_next;

    // west_reg and mid_reg hold the newer row at columns c-1 and c.
    logic [hfps_pkg::SAMPLE_W-1:0] west_reg, west_next;
    logic [hfps_pkg::SAMPLE_W-1:0] mid_reg, mid_next;
    logic [hfps_pkg::SAMPLE_W-1:0] col0_reg, col0_next;

    logic [COL_W-1:0] w_cl, w_end;
    logic [ROW_W-1:0] h_cl, h_end;
    logic             accept, row_end, emit;
    logic [COL_W:0]   ahead;
    logic [COL_W-1:0] ahead_addr, addr0, addr1;
    logic             we0, we1;
    logic [hfps_pkg::SAMPLE_W-1:0] rd0, rd1, older_rd, newer_rd;
    logic [hfps_pkg::GHOST_W-1:0]  adj;

    always_comb
    begin
        if (cfg.width_in_use == '0)
        begin
            w_cl = COL_W'(1);
        end
        else if (32'(cfg.width_in_use) > 32'(MAX_WIDTH))
        begin
            w_cl = COL_W'(MAX_WIDTH);
        end
        else
        begin
            w_cl = COL_W'(cfg.width_in_use);
        end

        if (cfg.height_in_use == '0)
        begin
            h_cl = ROW_W'(1);
        end
        else if (32'(cfg.height_in_use) > 32'(MAX_HEIGHT))
        begin
            h_cl = ROW_W'(MAX_HEIGHT);
        end
        else
        begin
            h_cl = ROW_W'(cfg.height_in_use);
        end
    end

    assign w_end = w_cl + COL_W'(1);
    assign h_end = h_cl + ROW_W'(1);

    assign in_stall = cell_valid_reg && !cell_take;
    assign accept   = in_valid && !in_stall;
    assign row_end  = (col_reg >= w_end);
    assign emit     = (row_reg >= ROW_W'(2)) && (row_reg <= h_end)
                   && (col_reg != '0) && (col_reg <= w_cl);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        bank_next = bank_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next  = '0;
                bank_next = !bank_reg;
                row_next  = (row_reg >= h_end) ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // The read for the next pending column is issued ahead of its sample, so the
    // older row at c and the newer row at c+1 are ready when that sample arrives.
    assign ahead      = {1'b0, col_next} + (COL_W + 1)'(1);
    assign ahead_addr = (ahead > (COL_W + 1)'(DEPTH - 1)) ? COL_W'(DEPTH - 1)
                                                          : ahead[COL_W-1:0];
    assign addr0 = bank_next ? ahead_addr : col_next;
    assign addr1 = bank_next ? col_next : ahead_addr;
    assign we0   = accept && !bank_reg;
    assign we1   = accept && bank_reg;

    hfps_ram #(
        .WIDTH (hfps_pkg::SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store0 (
        .clk     (clk),
        .wr_en   (we0),
        .wr_addr (col_reg),
        .wr_data (sample_value),
        .rd_addr (addr0),
        .rd_data (rd0)
    );

    hfps_ram #(
        .WIDTH (hfps_pkg::SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store1 (
        .clk     (clk),
        .wr_en   (we1),
        .wr_addr (col_reg),
        .wr_data (sample_value),
        .rd_addr (addr1),
        .rd_data (rd1)
    );

    assign older_rd = bank_reg ? rd1 : rd0;
    assign newer_rd = bank_reg ? rd0 : rd1;

    // Column zero of the row being written is kept aside; at the row end it
    // becomes the west ghost of the next row's window.
    always_comb
    begin
        west_next = west_reg;
        mid_next  = mid_reg;
        col0_next = col0_reg;
        if (accept)
        begin
            west_next = mid_reg;
            mid_next  = row_end ? col0_reg : newer_rd;
            if (col_reg == '0)
            begin
                col0_next = sample_value;
            end
        end
    end

    assign adj = hfps_pkg::GHOST_W'($signed(mid_reg));

    always_comb
    begin
        cell_next.u  = mid_reg;
        cell_next.uw = hfps_pkg::GHOST_W'($signed(west_reg));
        cell_next.ue = hfps_pkg::GHOST_W'($signed(newer_rd));
        cell_next.us = hfps_pkg::GHOST_W'($signed(older_rd));
        cell_next.un = hfps_pkg::GHOST_W'($signed(sample_value));
        if (col_reg == COL_W'(1))
        begin
            cell_next.uw = hfps_pkg::ghost_value(cfg.neighbor_sides[hfps_pkg::SIDE_WEST],
                cfg.neumann_sides[hfps_pkg::SIDE_WEST], cfg.internal_bc, cell_next.uw, adj);
        end
        if (col_reg == w_cl)
        begin
            cell_next.ue = hfps_pkg::ghost_value(cfg.neighbor_sides[hfps_pkg::SIDE_EAST],
                cfg.neumann_sides[hfps_pkg::SIDE_EAST], cfg.internal_bc, cell_next.ue, adj);
        end
        if (row_reg == ROW_W'(2))
        begin
            cell_next.us = hfps_pkg::ghost_value(cfg.neighbor_sides[hfps_pkg::SIDE_SOUTH],
                cfg.neumann_sides[hfps_pkg::SIDE_SOUTH], cfg.internal_bc, cell_next.us, adj);
        end
        if (row_reg == h_end)
        begin
            cell_next.un = hfps_pkg::ghost_value(cfg.neighbor_sides[hfps_pkg::SIDE_NORTH],
                cfg.neumann_sides[hfps_pkg::SIDE_NORTH], cfg.internal_bc, cell_next.un, adj);
        end
        cell_next.last = (row_reg == h_end) && (col_reg == w_cl);
    end

    always_comb
    begin
        if (accept)
        begin
            cell_valid_next = emit;
        end
        else if (cell_take)
        begin
            cell_valid_next = 1'b0;
        end
        else
        begin
            cell_valid_next = cell_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            bank_reg       <= 1'b0;
            cell_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            bank_reg       <= bank_next;
            cell_valid_reg <= cell_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        west_reg <= west_next;
        mid_reg  <= mid_next;
        col0_reg <= col0_next;
        if (accept)
        begin
            cell_reg <= cell_next;
        end
    end

    assign stencil    = cell_reg;
    assign cell_valid = cell_valid_reg;

endmodule

// ----- rtl/core/hfps_arith.sv -----
// Arithmetic pipeline: second differences, split products, sums and saturation.
module hfps_arith (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hfps_pkg::cfg_t                cfg,
    input  hfps_pkg::cell_t               stencil,
    input  logic                          cell_valid,
    output logic                          cell_take,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [hfps_pkg::SAMPLE_W-1:0] result_value,
    output logic                          saturated,
    output logic                          last_of_patch
);

    typedef struct packed {
        logic [34:0] dx;
        logic [34:0] dy;
        logic [31:0] u;
        logic        last;
    } diff_t;

    typedef struct packed {
        logic [59:0] p_hx;
        logic [51:0] p_lx;
        logic [59:0] p_hy;
        logic [51:0] p_ly;
        logic [63:0] p_l;
        logic        last;
    } prod_t;

    typedef struct packed {
        logic [60:0] fx;
        logic [60:0] fy;
        logic [47:0] fl;
        logic        last;
    } part_t;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
        logic        last;
    } res_t;

    diff_t s2_reg, s2_next;
    prod_t s3_reg, s3_next;
    part_t s4_reg, s4_next;
    res_t  res_reg, res_next;
    logic  v2_reg, v3_reg, v4_reg, v5_reg;
    logic  ld2, ld3, ld4, ld5;
    logic signed [62:0] f_sum;
    logic  pos_ovf, neg_ovf;

    // A stage loads when it is empty or its content moves on, so bubbles collapse.
    assign ld5 = !v5_reg || !out_stall;
    assign ld4 = !v4_reg || ld5;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign cell_take = ld2;

    always_comb
    begin
        s2_next.dx = 35'($signed(stencil.ue)) + 35'($signed(stencil.uw))
                   - (35'($signed(stencil.u)) <<< 1);
        s2_next.dy = 35'($signed(stencil.un)) + 35'($signed(stencil.us))
                   - (35'($signed(stencil.u)) <<< 1);
        s2_next.u    = stencil.u;
        s2_next.last = stencil.last;
    end

    // Each reciprocal is split at the binary point into a 24-bit integer part
    // and a 16-bit fraction part; the fraction product is floored separately.
    always_comb
    begin
        s3_next.p_hx = 60'($signed(s2_reg.dx)) * 60'($signed({1'b0, cfg.inv_dx2[39:16]}));
        s3_next.p_lx = 52'($signed(s2_reg.dx)) * 52'($signed({1'b0, cfg.inv_dx2[15:0]}));
        s3_next.p_hy = 60'($signed(s2_reg.dy)) * 60'($signed({1'b0, cfg.inv_dy2[39:16]}));
        s3_next.p_ly = 52'($signed(s2_reg.dy)) * 52'($signed({1'b0, cfg.inv_dy2[15:0]}));
        s3_next.p_l  = 64'($signed(cfg.lambda_coeff)) * 64'($signed(s2_reg.u));
        s3_next.last = s2_reg.last;
    end

    always_comb
    begin
        s4_next.fx   = 61'($signed(s3_reg.p_hx)) + 61'($signed(s3_reg.p_lx[51:16]));
        s4_next.fy   = 61'($signed(s3_reg.p_hy)) + 61'($signed(s3_reg.p_ly[51:16]));
        s4_next.fl   = s3_reg.p_l[63:16];
        s4_next.last = s3_reg.last;
    end

    assign f_sum = 63'($signed(s4_reg.fx)) + 63'($signed(s4_reg.fy))
                 + 63'($signed(s4_reg.fl));
    assign pos_ovf = !f_sum[62] && (f_sum[61:31] != '0);
    assign neg_ovf = f_sum[62] && (f_sum[61:31] != '1);

    always_comb
    begin
        if (pos_ovf)
        begin
            res_next.value = hfps_pkg::SAT_POS;
        end
        else if (neg_ovf)
        begin
            res_next.value = hfps_pkg::SAT_NEG;
        end
        else
        begin
            res_next.value = f_sum[31:0];
        end
        res_next.sat  = pos_ovf || neg_ovf;
        res_next.last = s4_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (ld2)
            begin
                v2_reg <= cell_valid;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
            if (ld4)
            begin
                v4_reg <= v3_reg;
            end
            if (ld5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            s2_reg <= s2_next;
        end
        if (ld3)
        begin
            s3_reg <= s3_next;
        end
        if (ld4)
        begin
            s4_reg <= s4_next;
        end
        if (ld5)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = v5_reg;
    assign result_value  = res_reg.value;
    assign saturated     = res_reg.sat;
    assign last_of_patch = res_reg.last;

endmodule

// ----- rtl/core/helmholtz_five_point_stencil_top.sv -----
// A cell goes from the window register through stages s2, s3, s4 to the result register.
// Throughput: one sample per cycle unless stalled; row stores read one column ahead of the stream.
// Stalls propagate only through occupied pipeline stages; empty stages keep filling.
// Reset: counters, row-store bank select and stage valids clear; configuration registers
// take their reset values. The row stores are not cleared; no unwritten entry reaches a result.
module helmholtz_five_point_stencil_top #(
    parameter int MAX_WIDTH  = hfps_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = hfps_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [hfps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hfps_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [hfps_pkg::SAMPLE_W-1:0]  sample_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [hfps_pkg::SAMPLE_W-1:0]  result_value,
    output logic                           saturated,
    output logic                           last_of_patch
);

    hfps_pkg::cfg_t  cfg;
    hfps_pkg::cell_t stencil;
    logic            cell_valid;
    logic            cell_take;

    hfps_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    hfps_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_value (sample_value),
        .stencil      (stencil),
        .cell_valid   (cell_valid),
        .cell_take    (cell_take)
    );

    hfps_arith u_arith (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .stencil       (stencil),
        .cell_valid    (cell_valid),
        .cell_take     (cell_take),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_value  (result_value),
        .saturated     (saturated),
        .last_of_patch (last_of_patch)
    );

    // The input side can only be held off when every stage is full behind a stalled result.
    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall)
    ) else $error("input request stalled while the output side is free");

    a_sat_value: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
            (result_value == hfps_pkg::SAT_POS || result_value == hfps_pkg::SAT_NEG)
    ) else $error("saturated result is not at a range limit");

    a_no_stall_from_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!out_valid && !cell_valid) |=> !in_stall
    ) else $error("input request stalled one cycle after an empty pipeline");

endmodule
